@@ src/cdq_pkg.sv @@
// Shared constants, operation and status codes, and the controller command
// struct for the circular deque. No dependencies.
package cdq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;
  localparam int OP_W          = 3;
  localparam int STAT_W        = 2;

  // Operation codes; codes above OP_POP_REAR act as no operation.
  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic load_in;   // capture the input item
    logic update;    // move indices, write the ring
    logic read;      // read front and rear slots
    logic load_out;  // load the result register
  } cdq_cmd_t;

endpackage

@@ src/cdq_in_if.sv @@
// Input channel: valid/ready handshake carrying one deque operation.
// Depends on cdq_pkg.
interface cdq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cdq_pkg::OP_W-1:0]              operation;
  logic signed [cdq_pkg::DATA_W-1:0]     data_value;

  modport source (output valid, output operation, output data_value, input ready);
  modport sink   (input valid, input operation, input data_value, output ready);
endinterface

@@ src/cdq_out_if.sv @@
// Output channel: valid/ready handshake carrying one deque result.
// Depends on cdq_pkg.
interface cdq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [cdq_pkg::STAT_W-1:0]            status;
  logic signed [cdq_pkg::DATA_W-1:0]     front_value;
  logic signed [cdq_pkg::DATA_W-1:0]     rear_value;
  logic                                  is_empty;
  logic                                  is_full;

  modport source (output valid, output status, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

@@ src/cdq_ctrl.sv @@
// Sequencer for the circular deque: steps one item through update, read
// and result load. Depends on cdq_pkg.
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_READ,
    S_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == S_IDLE) && in_valid;
    cmd.update   = (state == S_UPDATE);
    cmd.read     = (state == S_READ);
    cmd.load_out = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE:   if (in_valid) state <= S_UPDATE;
        S_UPDATE: state <= S_READ;
        S_READ:   state <= S_DONE;
        S_DONE:   if (!out_valid || out_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/cdq_datapath.sv @@
// Ring memory, head/tail indices, empty flag and result register of the
// circular deque. Depends on cdq_pkg.
module cdq_datapath #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cdq_pkg::cdq_cmd_t                 cmd,
  input  logic [cdq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [cdq_pkg::DATA_W-1:0] in_data_value,
  output logic [cdq_pkg::STAT_W-1:0]        out_status,
  output logic signed [cdq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [cdq_pkg::DATA_W-1:0] out_rear_value,
  output logic                              out_is_empty,
  output logic                              out_is_full
);
  import cdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic signed [DATA_W-1:0] ring_store [DEPTH];

  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic [IW-1:0]            head;
  logic [IW-1:0]            tail;
  logic                     empty;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] rd_front;
  logic signed [DATA_W-1:0] rd_rear;

  logic [IW-1:0]     head_next;
  logic [IW-1:0]     tail_next;
  logic              empty_next;
  logic [STAT_W-1:0] status_next;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              full;
  logic              is_push;
  logic              is_pop;
  logic [IW-1:0]     tail_inc;
  logic [IW-1:0]     head_inc;
  logic [IW-1:0]     head_dec;
  logic [IW-1:0]     tail_dec;

  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST : head - 1'b1;
  assign tail_dec = (tail == '0) ? LAST : tail - 1'b1;
  assign full     = !empty && (tail_inc == head);
  assign is_push  = op inside {OP_PUSH_FRONT, OP_PUSH_REAR};
  assign is_pop   = op inside {OP_POP_FRONT, OP_POP_REAR};

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    status_next = STAT_DONE;
    wr_en       = 1'b0;
    wr_addr     = '0;
    if (is_push) begin
      if (full) begin
        status_next = STAT_FULL;
      end else begin
        wr_en = 1'b1;
        if (empty) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
        end else if (op == OP_PUSH_FRONT) begin
          head_next = head_dec;
          wr_addr   = head_dec;
        end else begin
          tail_next = tail_inc;
          wr_addr   = tail_inc;
        end
      end
    end else if (is_pop) begin
      if (empty) begin
        status_next = STAT_EMPTY;
      end else if (head == tail) begin
        empty_next = 1'b1;
        head_next  = '0;
        tail_next  = '0;
      end else if (op == OP_POP_FRONT) begin
        head_next = head_inc;
      end else begin
        tail_next = tail_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else if (cmd.update) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op    <= in_operation;
      value <= in_data_value;
    end
    if (cmd.update) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) begin
      ring_store[wr_addr] <= value;
    end
    if (cmd.read) begin
      rd_front <= ring_store[head];
      rd_rear  <= ring_store[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status      <= status;
      out_front_value <= empty ? EMPTY_VALUE : rd_front;
      out_rear_value  <= empty ? EMPTY_VALUE : rd_rear;
      out_is_empty    <= empty;
      out_is_full     <= full;
    end
  end

  a_empty_home: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == '0) && (tail == '0))
    else $error("empty deque with indices off slot zero");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && is_push && full) |=> $stable(head) && $stable(tail) && !empty)
    else $error("refused push changed the indices");

  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && is_pop && empty) |=> empty && (status == STAT_EMPTY))
    else $error("pop from empty deque not refused");

endmodule

@@ src/circular_deque.sv @@
// Circular deque: a double-ended queue in a ring of DEPTH signed 32-bit words.
// Each item passes from input transfer through index update, ring read and
// result load before its result is valid; a new item is taken only once the
// sequencer is idle again. The result register frees the input side while a
// result waits, but result load stalls until the previous result is taken.
// Reset (rst, synchronous): deque empty, head and tail at slot 0, no result.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  cdq_in_if.sink    req,
  cdq_out_if.source rsp
);
  import cdq_pkg::*;

  // Command bundle from the sequencer to the datapath.
  cdq_cmd_t cmd;

  // Sequencer: owns the handshakes and the result valid flag.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Datapath: ring memory, indices and the result register that holds
  // the payload of the pending transfer.
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_operation    (req.operation),
    .in_data_value   (req.data_value),
    .out_status      (rsp.status),
    .out_front_value (rsp.front_value),
    .out_rear_value  (rsp.rear_value),
    .out_is_empty    (rsp.is_empty),
    .out_is_full     (rsp.is_full)
  );

endmodule
